// ----- hw/rtl/battery_charge_estimator_macros.svh -----
// Assertion macros for the battery charge estimator.
// Included by the top level; no other dependencies.
`ifndef BATTERY_CHARGE_ESTIMATOR_MACROS_SVH
`define BATTERY_CHARGE_ESTIMATOR_MACROS_SVH

// Implication checked every clock outside reset
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bce_pkg.sv -----
// Package for the battery charge estimator: types and constants.
// No dependencies.
package bce_pkg;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_CHARGE = 2'd1;
	localparam logic [1:0] ACT_VEL    = 2'd2;
	localparam logic [1:0] ACT_SPEED  = 2'd3;

	localparam logic [2:0] REG_CAPACITY = 3'd0;
	localparam logic [2:0] REG_CHG_PWR  = 3'd1;
	localparam logic [2:0] REG_MOV_PWR  = 3'd2;
	localparam logic [2:0] REG_STD_PWR  = 3'd3;
	localparam logic [2:0] REG_FLOOR    = 3'd4;

	localparam int TIME_BITS = 40;
	localparam int Q_BITS    = 17;
	// Working width of the shift-and-add / restoring divide unit
	localparam int DW = 96;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [16:0] ONE_Q16  = 17'd65536;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FULL_M, ST_FULL_W,
		ST_ADD_M, ST_ADD_W,
		ST_FRAC_D, ST_FRAC_W,
		ST_SOC_M, ST_SOC_MW, ST_SOC_D, ST_SOC_DW,
		ST_TTF_M, ST_TTF_MW, ST_TTF_D, ST_TTF_DW,
		ST_TM_M, ST_TM_MW, ST_TM_D, ST_TM_DW,
		ST_TS_M, ST_TS_MW, ST_TS_D, ST_TS_DW,
		ST_RUN_D, ST_RUN_DW,
		ST_DNUM_M, ST_DNUM_MW,
		ST_DIST_M, ST_DIST_MW, ST_DIST_D, ST_DIST_DW,
		ST_OUT
	} state_t;

	// Command to the serial arithmetic unit
	typedef struct packed {
		logic start;
		logic is_div;
	} arith_cmd_t;

endpackage

// ----- hw/rtl/battery_charge_estimator.sv -----
// Battery charge estimator (coulomb-counting fuel gauge), top level.
// Depends on bce_pkg, bce_serial_arith and battery_charge_estimator_macros.svh.
//
// A tick runs every product and quotient through one shared 96-bit serial unit
// at one bit per cycle, fifteen operations (fourteen when charging) in turn,
// and then loads the result register. The input stalls while a tick is in
// work or while a held result is stalled; the result waits in an output
// register.
module battery_charge_estimator #(
	parameter int CHARGE_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] elapsed_ms,
	input  logic signed [15:0] linear_speed,
	input  logic signed [15:0] angular_speed,
	input  logic [13:0] avg_speed_mm_s,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        charging,
	output logic [6:0]  soc_percent,
	output logic [31:0] time_to_full_s,
	output logic [31:0] run_time_s,
	output logic [31:0] distance_mm,
	output logic        depleted,
	output logic        full_res
);
	import bce_pkg::*;
`include "battery_charge_estimator_macros.svh"

	localparam logic [CHARGE_BITS-1:0] CMAX = {CHARGE_BITS{1'b1}};

	logic [19:0] cap_q, cpw_q, mpw_q, spw_q;
	logic [13:0] floor_q, spd_q;
	logic [CHARGE_BITS-1:0] chg_q, full_q;
	logic        chg_flag_q, mov_q, depl_q, gfull_q, clamp_q;
	logic [TIME_BITS-1:0] tm_q, ts_q;
	logic [Q_BITS-1:0] frac_q;
	logic [15:0] el_q;
	logic [DW-1:0] tmp_q, tmq_q;
	logic [6:0]  soc_q;
	logic [31:0] ttf_q, run_q, dist_q;
	logic        sat_q, ov_valid_q;
	state_t      st_q, st_d;

	arith_cmd_t  cmd;
	logic [DW-1:0] op_a, op_b, ar_res;
	logic        ar_busy;

	bce_serial_arith u_arith (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op_a(op_a), .op_b(op_b),
		.busy(ar_busy), .result(ar_res)
	);

	logic in_acc, tick_acc, idle;
	assign idle      = (st_q == ST_IDLE);
	assign in_stall  = !idle || (ov_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign tick_acc  = in_acc && action == ACT_TICK && elapsed_ms != 16'd0;
	assign cfg_ready = idle && !clamp_q;

	// Saturate a quotient to 32 bits
	function automatic logic [31:0] sat32(input logic [DW-1:0] v);
		sat32 = (v > DW'(SAT32)) ? SAT32 : v[31:0];
	endfunction

	// Draw power, time increments and sums
	logic [19:0] pwr;
	logic [TIME_BITS:0] tsum, tnew;
	logic [TIME_BITS-1:0] tsat;
	logic [DW-1:0] cext, fullext;
	assign pwr     = mov_q ? mpw_q : spw_q;
	assign tnew    = {1'b0, mov_q ? tm_q : ts_q} + {{(TIME_BITS-15){1'b0}}, el_q};
	assign tsat    = tnew[TIME_BITS] ? {TIME_BITS{1'b1}} : tnew[TIME_BITS-1:0];
	assign tsum    = {1'b0, tm_q} + {1'b0, ts_q};
	assign cext    = DW'(chg_q);
	assign fullext = DW'(full_q);

	// Full value after a capacity write, saturated to the charge width
	logic [47:0] cap_prod;
	logic [CHARGE_BITS-1:0] full_new;
	assign cap_prod = {28'd0, cap_q} * 48'd3600000;
	assign full_new = (cap_prod > 48'(CMAX)) ? CMAX : CHARGE_BITS'(cap_prod);

	// Sequencer: next state and operand selection
	always_comb begin
		st_d = st_q;
		cmd  = '0;
		op_a = '0;
		op_b = '0;
		case (st_q)
			ST_IDLE:    if (tick_acc) st_d = ST_FULL_M;
			ST_FULL_M: begin
				cmd = '{1'b1, 1'b0}; op_a = DW'(cap_q); op_b = DW'(32'd3600000);
				st_d = ST_FULL_W;
			end
			ST_FULL_W:  if (!ar_busy) st_d = ST_ADD_M;
			ST_ADD_M: begin
				cmd = '{1'b1, 1'b0}; op_a = DW'(chg_flag_q ? cpw_q : pwr);
				op_b = DW'(el_q); st_d = ST_ADD_W;
			end
			ST_ADD_W:   if (!ar_busy) st_d = chg_flag_q ? ST_SOC_M : ST_FRAC_D;
			ST_FRAC_D: begin
				cmd = '{1'b1, 1'b1}; op_a = DW'({tm_q, 16'd0}); op_b = DW'(tsum);
				st_d = ST_FRAC_W;
			end
			ST_FRAC_W:  if (!ar_busy) st_d = ST_SOC_M;
			ST_SOC_M: begin
				cmd = '{1'b1, 1'b0}; op_a = cext; op_b = DW'(7'd100);
				st_d = ST_SOC_MW;
			end
			ST_SOC_MW:  if (!ar_busy) st_d = ST_SOC_D;
			ST_SOC_D: begin
				cmd = '{1'b1, 1'b1}; op_a = ar_res; op_b = fullext;
				st_d = ST_SOC_DW;
			end
			ST_SOC_DW:  if (!ar_busy) st_d = ST_TTF_M;
			ST_TTF_M: begin
				cmd = '{1'b1, 1'b0}; op_a = DW'(cpw_q); op_b = DW'(10'd1000);
				st_d = ST_TTF_MW;
			end
			ST_TTF_MW:  if (!ar_busy) st_d = ST_TTF_D;
			ST_TTF_D: begin
				cmd = '{1'b1, 1'b1}; op_a = fullext - cext; op_b = ar_res;
				st_d = ST_TTF_DW;
			end
			ST_TTF_DW:  if (!ar_busy) st_d = ST_TM_M;
			ST_TM_M: begin
				cmd = '{1'b1, 1'b0}; op_a = cext; op_b = DW'(frac_q);
				st_d = ST_TM_MW;
			end
			ST_TM_MW:   if (!ar_busy) st_d = ST_TM_D;
			ST_TM_D: begin
				cmd = '{1'b1, 1'b1}; op_a = ar_res; op_b = DW'(mpw_q);
				st_d = ST_TM_DW;
			end
			ST_TM_DW:   if (!ar_busy) st_d = ST_TS_M;
			ST_TS_M: begin
				cmd = '{1'b1, 1'b0}; op_a = cext; op_b = DW'(ONE_Q16 - frac_q);
				st_d = ST_TS_MW;
			end
			ST_TS_MW:   if (!ar_busy) st_d = ST_TS_D;
			ST_TS_D: begin
				cmd = '{1'b1, 1'b1}; op_a = ar_res; op_b = DW'(spw_q);
				st_d = ST_TS_DW;
			end
			ST_TS_DW:   if (!ar_busy) st_d = ST_RUN_D;
			// Standing term counts as zero when the standing power is zero
			ST_RUN_D: begin
				cmd = '{1'b1, 1'b1};
				op_a = tmq_q + ((spw_q == '0) ? '0 : ar_res);
				op_b = DW'(32'd65536000);
				st_d = ST_RUN_DW;
			end
			ST_RUN_DW:  if (!ar_busy) st_d = ST_DNUM_M;
			ST_DNUM_M: begin
				cmd = '{1'b1, 1'b0}; op_a = DW'(spd_q); op_b = cext;
				st_d = ST_DNUM_MW;
			end
			ST_DNUM_MW: if (!ar_busy) st_d = ST_DIST_M;
			ST_DIST_M: begin
				cmd = '{1'b1, 1'b0}; op_a = DW'(mpw_q); op_b = DW'(10'd1000);
				st_d = ST_DIST_MW;
			end
			ST_DIST_MW: if (!ar_busy) st_d = ST_DIST_D;
			ST_DIST_D: begin
				cmd = '{1'b1, 1'b1}; op_a = tmp_q; op_b = ar_res;
				st_d = ST_DIST_DW;
			end
			ST_DIST_DW: if (!ar_busy) st_d = ST_OUT;
			ST_OUT:     if (!(ov_valid_q && out_stall)) st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	// Configuration, state updates and result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 20'd100000; cpw_q <= 20'd50000;
			mpw_q <= 20'd20000;  spw_q <= 20'd5000;
			floor_q <= 14'd500;  spd_q <= 14'd500;
			chg_q <= CHARGE_BITS'(64'd360000000000);
			full_q <= CHARGE_BITS'(64'd360000000000);
			chg_flag_q <= 1'b0; mov_q <= 1'b0;
			tm_q <= '0; ts_q <= '0; frac_q <= HALF_Q16;
			depl_q <= 1'b0; gfull_q <= 1'b0; clamp_q <= 1'b0;
			ov_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && !(ov_valid_q && out_stall))
				ov_valid_q <= 1'b1;
			else if (ov_valid_q && !out_stall)
				ov_valid_q <= 1'b0;
			clamp_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY: begin cap_q <= cfg_data; clamp_q <= 1'b1; end
					REG_CHG_PWR:  cpw_q <= cfg_data;
					REG_MOV_PWR:  mpw_q <= cfg_data;
					REG_STD_PWR:  spw_q <= cfg_data;
					REG_FLOOR:    floor_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			// After a capacity write the full value is refreshed by a product
			if (clamp_q) begin
				full_q <= full_new;
				if (full_new < chg_q)
					chg_q <= full_new;
			end
			if (in_acc) begin
				case (action)
					ACT_CHARGE: chg_flag_q <= 1'b1;
					ACT_VEL:    mov_q <= (linear_speed != '0) || (angular_speed != '0);
					ACT_SPEED:  spd_q <= (avg_speed_mm_s > floor_q) ? avg_speed_mm_s
						: floor_q;
					default:    el_q <= elapsed_ms;
				endcase
			end
			if (st_q == ST_FULL_W && !ar_busy)
				full_q <= (ar_res > DW'(CMAX)) ? CMAX : ar_res[CHARGE_BITS-1:0];
			if (st_q == ST_ADD_W && !ar_busy) begin
				depl_q  <= 1'b0; gfull_q <= 1'b0;
				if (chg_flag_q) begin
					if (cext + ar_res >= fullext) begin
						chg_q <= full_q; chg_flag_q <= 1'b0; gfull_q <= 1'b1;
					end else
						chg_q <= CHARGE_BITS'(cext + ar_res);
				end else begin
					if (ar_res >= cext) begin
						chg_q <= '0; depl_q <= 1'b1;
					end else
						chg_q <= CHARGE_BITS'(cext - ar_res);
					if (mov_q) tm_q <= tsat; else ts_q <= tsat;
				end
			end
			if (st_q == ST_FRAC_W && !ar_busy)
				frac_q <= (ar_res < DW'(HALF_Q16)) ? HALF_Q16 : ar_res[Q_BITS-1:0];
			if (st_q == ST_SOC_DW && !ar_busy)
				soc_q <= (full_q == '0) ? 7'd0 : ar_res[6:0];
			if (st_q == ST_TTF_DW && !ar_busy)
				ttf_q <= (cpw_q == '0) ? ((full_q != chg_q) ? SAT32 : '0) : sat32(ar_res);
			if (st_q == ST_TM_M)
				sat_q <= 1'b0;
			if (st_q == ST_TM_DW && !ar_busy) begin
				tmq_q <= (mpw_q == '0) ? '0 : ar_res;
				if (mpw_q == '0 && chg_q != '0) sat_q <= 1'b1;
			end
			if (st_q == ST_TS_DW && !ar_busy && spw_q == '0 && chg_q != '0
				&& frac_q != ONE_Q16)
				sat_q <= 1'b1;
			if (st_q == ST_RUN_DW && !ar_busy)
				run_q <= sat_q ? SAT32 : sat32(ar_res);
			// Distance numerator: average speed times charge
			if (st_q == ST_DNUM_MW && !ar_busy)
				tmp_q <= ar_res;
			if (st_q == ST_DIST_DW && !ar_busy)
				dist_q <= (mpw_q == '0) ? ((tmp_q != '0) ? SAT32 : '0) : sat32(ar_res);
			if (st_q == ST_OUT && !(ov_valid_q && out_stall)) begin
				charging       <= chg_flag_q;
				soc_percent    <= soc_q;
				time_to_full_s <= ttf_q;
				run_time_s     <= run_q;
				distance_mm    <= dist_q;
				depleted       <= depl_q;
				full_res       <= gfull_q;
			end
		end
	end

	assign out_valid = ov_valid_q;

	`BCE_ASSERT_IMP(a_stall_busy, clk, arst_n, !idle, in_stall,
		"input accepted while a tick is in work")
	`BCE_ASSERT_IMP(a_frac_floor, clk, arst_n, 1'b1, frac_q >= HALF_Q16,
		"moving fraction below one half")
	`BCE_ASSERT_IMP(a_charge_full, clk, arst_n, idle && !clamp_q, chg_q <= full_q,
		"charge above full")
	`BCE_ASSERT_NXT(a_out_excl, clk, arst_n, st_q == ST_OUT && !(ov_valid_q && out_stall),
		out_valid && !(depleted && full_res), "result not loaded or flags in conflict")
endmodule

// ----- hw/rtl/bce_serial_arith.sv -----
// Bit-serial multiplier (shift and add) and restoring divider, one bit per cycle.
// Depends on bce_pkg.
module bce_serial_arith (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bce_pkg::arith_cmd_t   cmd,
	input  logic [bce_pkg::DW-1:0] op_a,
	input  logic [bce_pkg::DW-1:0] op_b,
	output logic                  busy,
	output logic [bce_pkg::DW-1:0] result
);
	import bce_pkg::*;

	logic [DW-1:0] acc_q, sh_q, opb_q;
	logic [DW:0]   rem_q;
	logic [6:0]    cnt_q;
	logic          div_q, busy_q;
	logic [DW:0]   rem_sh, rem_sub;

	assign rem_sh  = {rem_q[DW-1:0], sh_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, opb_q};

	// Multiply: acc += a<<i when b[i]; divide: restoring, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(DW);
			div_q  <= cmd.is_div;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			rem_q <= '0;
			sh_q  <= op_a;
			opb_q <= op_b;
		end else if (busy_q) begin
			if (div_q) begin
				sh_q <= {sh_q[DW-2:0], ~rem_sub[DW]};
				rem_q <= rem_sub[DW] ? rem_sh : rem_sub;
			end else begin
				if (opb_q[0])
					acc_q <= acc_q + sh_q;
				sh_q  <= {sh_q[DW-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[DW-1:1]};
			end
		end
	end

	assign busy   = busy_q;
	assign result = div_q ? sh_q : acc_q;
endmodule
